// ===== src/group_reverse_stream_assert.svh =====
// Assertion macros shared by the checker.
`ifndef GROUP_REVERSE_STREAM_ASSERT_SVH
`define GROUP_REVERSE_STREAM_ASSERT_SVH

// Check a property outside reset.
`define GRS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define GRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/grs_pkg.sv =====
`timescale 1ns / 1ps

package grs_pkg;

  localparam int VALUE_W       = 32;
  localparam int CFG_W         = 5;
  localparam int MAX_GROUP_DEF = 16;

endpackage

// ===== src/grs_if.sv =====
`timescale 1ns / 1ps

interface grs_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [grs_pkg::VALUE_W-1:0] item_value;
  logic                              list_last;

  modport source (output valid, output item_value, output list_last, input ready);
  modport sink   (input valid, input item_value, input list_last, output ready);
endinterface

interface grs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [grs_pkg::VALUE_W-1:0] out_value;
  logic                              run_end;
  logic                              list_end;

  modport source (output valid, output out_value, output run_end, output list_end,
                  input ready);
  modport sink   (input valid, input out_value, input run_end, input list_end,
                  output ready);
endinterface

// ===== src/grs_ram.sv =====
`timescale 1ns / 1ps

module grs_ram #(
  parameter int WIDTH = grs_pkg::VALUE_W,
  parameter int DEPTH = grs_pkg::MAX_GROUP_DEF
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/group_reverse_stream.sv =====
// group_reverse_stream: reorders list elements in groups; a full group comes
// out reversed, one cut short by list_last in order. Input channel (items):
// one word per list element, item_value plus list_last on the final element.
// Output channel (results): out_value, run_end on the last word a given
// input caused, list_end on the final word of the whole list. group_size is
// written through cfg_we/cfg_data; the user must write it only while the
// block is idle, which the block does not enforce; 0 acts as 1, values
// above MAX_GROUP as MAX_GROUP. Words are stored in a one-port-write,
// one-port-read RAM of MAX_GROUP entries. An input that does not close a
// group leaves the block idle. An input that closes a group (count reaches
// group_size, or list_last) starts a readout: READ issues the first read,
// then LOAD passes one word per cycle while results is ready. Input is not
// taken during the readout; the RAM read port sets the pace of one word per
// cycle. A word left in the output register does not block the next input;
// a stalled receiver holds the readout. Reset (rst, synchronous) empties
// the group, clears out_valid and sets group_size to 1. The RAM needs no
// clearing: only entries written in the current group are read.
`timescale 1ns / 1ps

module group_reverse_stream #(
  parameter int MAX_GROUP = grs_pkg::MAX_GROUP_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [grs_pkg::CFG_W-1:0]  cfg_data,
  grs_in_if.sink                     items,
  grs_out_if.source                  results
);

  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int KW = (CW > grs_pkg::CFG_W) ? CW : grs_pkg::CFG_W;

  typedef enum logic [1:0] {IDLE, READ, LOAD} state_t;

  state_t                      state;
  logic [grs_pkg::CFG_W-1:0]   group_size;
  logic [CW-1:0]               fill_count;
  logic [CW-1:0]               n_q;
  logic [CW-1:0]               idx;
  logic                        rev;
  logic                        lst;
  logic                        rd_end;
  logic                        out_valid;
  logic [grs_pkg::VALUE_W-1:0] out_value;
  logic                        run_end;
  logic                        list_end;

  logic [KW-1:0]               k;
  logic [KW-1:0]               gs_ext;
  logic [CW-1:0]               n_in;
  logic                        accept;
  logic                        full;
  logic                        slot_free;
  logic                        load_word;
  logic                        rd_go;
  logic [CW-1:0]               rd_addr;
  logic [grs_pkg::VALUE_W-1:0] rd_data;

  always_comb begin
    gs_ext = KW'(group_size);
    if (group_size == '0) begin
      k = KW'(1);
    end else if (gs_ext > KW'(MAX_GROUP)) begin
      k = KW'(MAX_GROUP);
    end else begin
      k = gs_ext;
    end
  end

  assign n_in      = fill_count + CW'(1);
  assign full      = KW'(n_in) >= k;
  assign accept    = items.valid && items.ready;
  assign slot_free = !out_valid || results.ready;
  assign load_word = (state == LOAD) && slot_free;
  assign rd_go     = (state == READ) || (load_word && !rd_end);
  assign rd_addr   = rev ? (n_q - CW'(1) - idx) : idx;

  assign items.ready       = (state == IDLE);
  assign results.valid     = out_valid;
  assign results.out_value = out_value;
  assign results.run_end   = run_end;
  assign results.list_end  = list_end;

  grs_ram #(
    .WIDTH (grs_pkg::VALUE_W),
    .DEPTH (MAX_GROUP)
  ) u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (fill_count[AW-1:0]),
    .wdata (items.item_value),
    .re    (rd_go),
    .raddr (rd_addr[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      group_size <= grs_pkg::CFG_W'(1);
      fill_count <= '0;
      out_valid  <= 1'b0;
      idx        <= '0;
      rd_end     <= 1'b0;
    end else begin
      if (cfg_we) begin
        group_size <= cfg_data;
      end
      if (out_valid && results.ready && !load_word) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            if (full || items.list_last) begin
              n_q        <= n_in;
              idx        <= '0;
              rev        <= full;
              lst        <= items.list_last;
              fill_count <= '0;
              state      <= READ;
            end else begin
              fill_count <= n_in;
            end
          end
        end
        READ: begin
          rd_end <= (idx == n_q - CW'(1));
          idx    <= idx + CW'(1);
          state  <= LOAD;
        end
        LOAD: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_value <= rd_data;
            run_end   <= rd_end;
            list_end  <= rd_end && lst;
            if (rd_end) begin
              state <= IDLE;
            end else begin
              rd_end <= (idx == n_q - CW'(1));
              idx    <= idx + CW'(1);
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== src/grs_checker.sv =====
`timescale 1ns / 1ps
`include "group_reverse_stream_assert.svh"

module grs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [grs_pkg::VALUE_W-1:0] out_value,
  input logic                        out_run_end,
  input logic                        out_list_end
);

  `GRS_ASSERT(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_value), "stalled word changed")
  `GRS_ASSERT(a_list_run, clk, rst, out_valid && out_list_end |-> out_run_end, "list_end without run_end")
  `GRS_ASSERT(a_last_busy, clk, rst, in_valid && in_ready && in_last |=> !in_ready, "list end did not start readout")
  `GRS_ASSERT_ALWAYS(a_reset, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind group_reverse_stream grs_checker u_grs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (items.valid),
  .in_ready     (items.ready),
  .in_last      (items.list_last),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_value    (results.out_value),
  .out_run_end  (results.run_end),
  .out_list_end (results.list_end)
);
